// ===== src/plet_pkg.sv =====
// Shared types, register codes and reset values for the pixel LSB entropy transposer.
// Used by plet_ctrl and the top level; depends on nothing else.
package plet_pkg;

  // Default for the largest matrix side the store is sized for.
  localparam int MAX_SIDE_DEF = 64;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [1:0] REG_SIDE      = 2'd2;

  // Register reset values.
  localparam logic [7:0] BAND_LOW_RST  = 8'd2;
  localparam logic [7:0] BAND_HIGH_RST = 8'd253;
  localparam logic [6:0] SIDE_RST      = 7'd64;

  // Input word action codes.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // One input word.
  typedef struct packed {
    logic       action;
    logic [7:0] brightness;
    logic       frame_end;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic        out_bit;
    logic        bit_valid;
    logic        last_bit;
    logic        store_full;
    logic [12:0] bits_collected;
  } out_word_t;

  // Per-word control passed from the sequencer to the top level.
  typedef struct packed {
    logic mem_we;
    logic mem_re;
    logic wr_bit;
    logic bit_valid;
    logic last_bit;
    logic store_full;
  } step_ctl_t;

endpackage

// ===== src/plet_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; holds its read data while no read is requested.
module plet_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/plet_ctrl.sv =====
// Fill and drain sequencer: band filter, frame parity, transposed write address and
// row-major drain index. Depends on plet_pkg.
module plet_ctrl #(
  parameter int MAX_SIDE = plet_pkg::MAX_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  plet_pkg::in_word_t                     word,
  input  logic [7:0]                             band_low,
  input  logic [7:0]                             band_high,
  input  logic [6:0]                             matrix_side,
  input  logic                                   side_wr,
  output plet_pkg::step_ctl_t                    ctl,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   wr_addr,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   rd_addr,
  output logic [12:0]                            bits_collected
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int CW = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int TW = 2 * SW;
  localparam int LW = (SW > 7) ? SW : 7;

  logic [SW-1:0] row_r, row_nxt;
  logic [SW-1:0] col_r, col_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] drain_r, drain_nxt;
  logic          even_r, even_nxt;

  logic [LW-1:0]    side_ext;
  logic [SW-1:0]    side;
  logic [TW-1:0]    total;
  logic             full_now;
  logic             keep;
  logic             drain;
  logic [CW+12:0]   fill_wide;

  // Effective side: zero acts as one, anything above the store size is clamped.
  always_comb begin
    side_ext = LW'(matrix_side);
    if (side_ext == '0) begin
      side_ext = LW'(1);
    end else if (side_ext > LW'(MAX_SIDE)) begin
      side_ext = LW'(MAX_SIDE);
    end
    side  = side_ext[SW-1:0];
    total = TW'(side) * TW'(side);
  end

  assign full_now = TW'(fill_r) >= total;
  assign keep  = accept && (word.action == plet_pkg::ACT_SAMPLE) && !full_now &&
                 (word.brightness >= band_low) && (word.brightness <= band_high);
  assign drain = accept && (word.action == plet_pkg::ACT_READ) && full_now &&
                 (TW'(drain_r) < total);

  // Next state of the counters; the write address walks down a column by adding the side.
  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    addr_nxt  = addr_r;
    fill_nxt  = fill_r;
    drain_nxt = drain_r;
    even_nxt  = even_r;
    if (keep) begin
      fill_nxt = fill_r + CW'(1);
      if (row_r + SW'(1) >= side) begin
        row_nxt  = '0;
        col_nxt  = col_r + SW'(1);
        addr_nxt = AW'(col_r) + AW'(1);
      end else begin
        row_nxt  = row_r + SW'(1);
        addr_nxt = addr_r + AW'(side);
      end
    end
    if (accept && (word.action == plet_pkg::ACT_SAMPLE) && word.frame_end) begin
      even_nxt = !even_r;
    end
    if (drain) begin
      drain_nxt = drain_r + CW'(1);
    end
  end

  // State registers; a side write empties the store but keeps the frame parity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      addr_r  <= '0;
      fill_r  <= '0;
      drain_r <= '0;
      even_r  <= 1'b0;
    end else if (side_wr) begin
      row_r   <= '0;
      col_r   <= '0;
      addr_r  <= '0;
      fill_r  <= '0;
      drain_r <= '0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      addr_r  <= addr_nxt;
      fill_r  <= fill_nxt;
      drain_r <= drain_nxt;
      even_r  <= even_nxt;
    end
  end

  // Memory requests and the status fields of the result word.
  always_comb begin
    ctl.mem_we     = keep;
    ctl.mem_re     = drain;
    ctl.wr_bit     = word.brightness[0] ^ even_r;
    ctl.bit_valid  = drain;
    ctl.last_bit   = drain && ((TW'(drain_r) + TW'(1)) == total);
    ctl.store_full = TW'(fill_nxt) >= total;
  end

  assign wr_addr        = addr_r;
  assign rd_addr        = drain_r[AW-1:0];
  assign fill_wide      = (CW + 13)'(fill_nxt);
  assign bits_collected = fill_wide[12:0];

endmodule

// ===== src/pixel_lsb_entropy_transposer.sv =====
// Top level of the pixel LSB entropy transposer: configuration registers, bit store,
// sequencer and result register. Depends on plet_pkg, plet_ram and plet_ctrl.
//
// Usage:
//   Input words (in_word) carry either a pixel sample or a read request and are
//   taken when in_valid is high and in_stall low. Every input word gives exactly one
//   result word on out_word, handed over when out_valid is high and out_stall low.
//   Samples inside [band_low, band_high] give their least significant bit, inverted
//   on even frames, which is stored column by column in a square store of side
//   matrix_side. Once the store is full, read words drain it row by row.
//   The result word is registered in the output register once its input word has passed
//   the read stage, which waits for the bit store's registered read port. in_stall is
//   high while a word is in the read stage, so a new word is taken while an earlier
//   result still waits in the output register.
//   If the receiver stalls, the result holds in the output register, and the one word
//   after it waits in the read stage until the register frees.
//   Reset clears the counters, the frame parity (first frame odd) and the registers to
//   band 2..253 and side 64; the store contents need no clearing.
//   Configuration goes through an APB-style port at byte addresses 0, 4 and 8.
//   Writing matrix_side empties the store.
module pixel_lsb_entropy_transposer #(
  parameter int MAX_SIDE = plet_pkg::MAX_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plet_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output plet_pkg::out_word_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

  logic [7:0] band_low_r;
  logic [7:0] band_high_r;
  logic [6:0] side_r;
  logic       cfg_wr;
  logic       side_wr;

  logic                in_accept;
  plet_pkg::step_ctl_t ctl;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [12:0]         bits_collected;
  logic                ram_rdata;

  logic                pend_r;
  plet_pkg::step_ctl_t pend_ctl_r;
  logic [12:0]         pend_cnt_r;
  logic                pend_done;
  plet_pkg::out_word_t out_r;
  logic                out_valid_r;

  // Configuration writes.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign side_wr = cfg_wr && (paddr[3:2] == plet_pkg::REG_SIDE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= plet_pkg::BAND_LOW_RST;
      band_high_r <= plet_pkg::BAND_HIGH_RST;
      side_r      <= plet_pkg::SIDE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        plet_pkg::REG_BAND_LOW:  band_low_r  <= pwdata[7:0];
        plet_pkg::REG_BAND_HIGH: band_high_r <= pwdata[7:0];
        plet_pkg::REG_SIDE:      side_r      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Configuration reads.
  always_comb begin
    unique case (paddr[3:2])
      plet_pkg::REG_BAND_LOW:  prdata = 32'(band_low_r);
      plet_pkg::REG_BAND_HIGH: prdata = 32'(band_high_r);
      plet_pkg::REG_SIDE:      prdata = 32'(side_r);
      default:                 prdata = '0;
    endcase
  end

  // A word is taken whenever the read stage is free.
  assign in_stall  = pend_r;
  assign in_accept = in_valid && !in_stall;

  plet_ctrl #(
    .MAX_SIDE(MAX_SIDE)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .word          (in_word),
    .band_low      (band_low_r),
    .band_high     (band_high_r),
    .matrix_side   (side_r),
    .side_wr       (side_wr),
    .ctl           (ctl),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .bits_collected(bits_collected)
  );

  plet_ram #(
    .WIDTH(1),
    .DEPTH(MAX_SIDE * MAX_SIDE)
  ) u_store (
    .clk  (clk),
    .we   (ctl.mem_we),
    .waddr(wr_addr),
    .wdata(ctl.wr_bit),
    .re   (ctl.mem_re),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Read stage: holds the word's status while the store read completes.
  assign pend_done = pend_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_accept) begin
      pend_r <= 1'b1;
    end else if (pend_done) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_ctl_r <= ctl;
      pend_cnt_r <= bits_collected;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_done) begin
      out_r.out_bit        <= ram_rdata && pend_ctl_r.bit_valid;
      out_r.bit_valid      <= pend_ctl_r.bit_valid;
      out_r.last_bit       <= pend_ctl_r.last_bit;
      out_r.store_full     <= pend_ctl_r.store_full;
      out_r.bits_collected <= pend_cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  // A drained bit only ever comes from a full store.
  a_bit_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bit_valid |-> out_word.store_full)
    else $error("drained bit reported while the store is not full");

  // The last bit is always a drained bit.
  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last_bit |-> out_word.bit_valid)
    else $error("last bit flagged on a word without a drained bit");

  // The store is never written and read for the same word.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mem_we && ctl.mem_re))
    else $error("bit store written and read by one word");

  // A side write empties the store.
  a_side_clears: assert property (@(posedge clk) disable iff (!rst_n)
    side_wr |=> !in_accept || (bits_collected <= 13'd1))
    else $error("store not emptied after a side write");
`endif

endmodule
